>>> hw/rtl/lzvn_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lzvn_pkg
// Shared types and constants of the LZVN stream decoder.
// ---------------------------------------------------------------------------
package lzvn_pkg;

	localparam int unsigned MAX_LANES   = 8;
	localparam int unsigned MAX_RESULTS = 34;
	localparam int unsigned PC_W        = 17;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_END   = 2'd1;
	localparam logic [1:0] ST_BADOP = 2'd2;
	localparam logic [1:0] ST_DIST  = 2'd3;

	localparam logic [7:0] OP_LMATCH = 8'hF0;
	localparam logic [7:0] OP_LLIT   = 8'hE0;
	localparam logic [7:0] OP_NOP0   = 8'h0E;
	localparam logic [7:0] OP_NOP1   = 8'h16;
	localparam logic [7:0] OP_EOS    = 8'h06;
	localparam logic [7:0] OP_UND0   = 8'h1E;
	localparam logic [7:0] OP_UND1   = 8'h26;
	localparam logic [7:0] OP_UND2   = 8'h2E;
	localparam logic [7:0] OP_UND3   = 8'h36;
	localparam logic [7:0] OP_UND4   = 8'h3E;
	localparam logic [3:0] HI_SMATCH = 4'hF;
	localparam logic [3:0] HI_SLIT   = 4'hE;
	localparam logic [3:0] HI_UND0   = 4'h7;
	localparam logic [3:0] HI_UND1   = 4'hD;
	localparam logic [2:0] TOP_MED   = 3'b101;
	localparam logic [2:0] LOW_LDIST = 3'b111;
	localparam logic [2:0] LOW_PDIST = 3'b110;

	typedef enum logic [3:0] {
		PH_HEADER, PH_OPCODE, PH_LMATCH_LEN, PH_LLIT_LEN, PH_MED_B1, PH_MED_B2,
		PH_LDIST_B1, PH_LDIST_B2, PH_SDIST, PH_LITERALS, PH_HALT
	} phase_t;

	typedef enum logic [1:0] {ACT_NONE, ACT_MATCH, ACT_STATUS} act_t;

	typedef enum logic [2:0] {B_IDLE, B_START, B_LIT, B_ACT, B_RD, B_WR, B_EMIT} bstate_t;

	// One entry per compressed word: optional restart, literal, then match or status
	typedef struct packed {
		logic        restart;
		logic        has_lit;
		logic [7:0]  lit;
		act_t        act;
		logic [1:0]  status;
		logic [15:0] distance;
		logic [8:0]  len;
	} cmd_t;

endpackage

>>> hw/rtl/lzvn_stream_decoder.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lzvn_stream_decoder
// LZVN decompressor taking one compressed word per transfer.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one compressed byte per word; tuser marks the first word of a
//   new stream, which clears history count, previous distance and halt.
//   m_axis carries results of up to eight decoded bytes with a count and a status;
//   tlast flags the final result caused by one input word.
//   cfg_* writes the header length (bytes dropped before the first opcode) and may
//   only be written while the decoder is idle.
// Timing:
//   The parser takes a word per cycle while its four-entry command queue has room.
//   The executor handles a literal word in steps: pop, start, write, finish.
//   A match takes a history read, then a write, for each byte, and an emit
//   step for each result; the longest match is 271 bytes. A literal word's
//   m_axis_tvalid rises from the output register after the pop, start and write.
// Reset and stalls:
//   arst_n clears all control state; the history ring is not cleared, and only
//   bytes already written are ever read. When m_axis stalls, the output register
//   holds its result, the executor waits, the queue fills and s_axis_tready drops.
// ---------------------------------------------------------------------------
module lzvn_stream_decoder #(
	parameter int unsigned HISTORY_DEPTH    = 65536,
	parameter int unsigned LANES_PER_RESULT = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data,      // header_length
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // in_byte
	input  logic        s_axis_tuser,  // stream_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,  // out_byte0..out_byte7, byte_count, 4 zero bits
	output logic [1:0]  m_axis_tuser,  // status
	output logic        m_axis_tlast   // last_of_run
);

	logic [3:0]     hdr_len_q;
	logic           q_full, q_empty, q_push, q_pop;
	lzvn_pkg::cmd_t q_wcmd, q_head;
	logic [7:0]     ob [lzvn_pkg::MAX_LANES];
	logic [3:0]     ocount;

	// Header length register, writable at any time the block is idle
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) hdr_len_q <= 4'd12;
		else if (cfg_valid) hdr_len_q <= cfg_data;
	end

	lzvn_front #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.header_length(hdr_len_q),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.in_byte      (s_axis_tdata),
		.stream_start (s_axis_tuser),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_cmd        (q_wcmd)
	);

	lzvn_cmd_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wcmd),
		.full  (q_full),
		.pop   (q_pop),
		.empty (q_empty),
		.rdata (q_head)
	);

	lzvn_back #(
		.HISTORY_DEPTH   (HISTORY_DEPTH),
		.LANES_PER_RESULT(LANES_PER_RESULT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_bytes (ob),
		.out_count (ocount),
		.out_status(m_axis_tuser),
		.out_last  (m_axis_tlast)
	);

	// Pack lanes lowest first, count above them, pad to whole bytes
	assign m_axis_tdata = {4'b0000, ocount, ob[7], ob[6], ob[5], ob[4],
		ob[3], ob[2], ob[1], ob[0]};

endmodule

>>> hw/rtl/lzvn_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lzvn_front
// Header skip and opcode parsing; issues at most one command per word.
// ---------------------------------------------------------------------------
module lzvn_front #(
	parameter int unsigned HISTORY_DEPTH = 65536
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [3:0]         header_length,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         in_byte,
	input  logic               stream_start,
	input  logic               q_full,
	output logic               q_push,
	output lzvn_pkg::cmd_t     q_cmd
);

	localparam logic [lzvn_pkg::PC_W-1:0] DEPTH_V = lzvn_pkg::PC_W'(HISTORY_DEPTH);

	lzvn_pkg::phase_t ph_q, ph;
	logic [3:0]  hc_q, hc;
	logic [8:0]  pl_q, pl;
	logic [8:0]  pm_q, pm;
	logic [7:0]  pd_q, pd;
	logic [7:0]  so_q, so;
	logic [15:0] prd_q, prd;
	logic [lzvn_pkg::PC_W-1:0] pc_q, pc_v;
	logic [lzvn_pkg::PC_W:0]   pc_sum;
	logic        dec, run_m;
	logic [8:0]  mlen;
	lzvn_pkg::cmd_t cmd;

	assign in_ready = !q_full;

	always_comb begin
		ph = ph_q; hc = hc_q; pl = pl_q; pm = pm_q; pd = pd_q; so = so_q;
		prd = prd_q; pc_v = pc_q; dec = 1'b0; run_m = 1'b0; mlen = '0;
		pc_sum = '0;
		cmd = '0;
		cmd.act = lzvn_pkg::ACT_NONE;
		if (stream_start) begin
			ph = lzvn_pkg::PH_HEADER; hc = '0; pl = '0; pm = '0; pd = '0; so = '0;
			prd = '0; pc_v = '0; cmd.restart = 1'b1;
		end
		case (ph)
			lzvn_pkg::PH_HALT: ;
			lzvn_pkg::PH_HEADER: begin
				if (hc >= header_length) dec = 1'b1;
				else hc = hc + 4'd1;
			end
			lzvn_pkg::PH_LMATCH_LEN: begin
				pm = 9'(in_byte) + 9'd16;
				ph = lzvn_pkg::PH_OPCODE;
				run_m = 1'b1;
			end
			lzvn_pkg::PH_LLIT_LEN: begin
				pl = 9'(in_byte) + 9'd16;
				pm = '0;
				ph = lzvn_pkg::PH_LITERALS;
			end
			lzvn_pkg::PH_MED_B1: begin
				pm = 9'({so[2:0], 2'b00}) + 9'(in_byte[1:0]) + 9'd3;
				pd = 8'(in_byte[7:2]);
				ph = lzvn_pkg::PH_MED_B2;
			end
			lzvn_pkg::PH_MED_B2: begin
				prd = 16'({in_byte, pd[5:0]});
				if (pl != '0) ph = lzvn_pkg::PH_LITERALS;
				else begin ph = lzvn_pkg::PH_OPCODE; run_m = 1'b1; end
			end
			lzvn_pkg::PH_LDIST_B1: begin
				pd = in_byte;
				ph = lzvn_pkg::PH_LDIST_B2;
			end
			lzvn_pkg::PH_LDIST_B2, lzvn_pkg::PH_SDIST: begin
				if (ph == lzvn_pkg::PH_LDIST_B2) prd = {in_byte, pd};
				else prd = {pd, in_byte};
				if (pl != '0) ph = lzvn_pkg::PH_LITERALS;
				else begin ph = lzvn_pkg::PH_OPCODE; run_m = 1'b1; end
			end
			lzvn_pkg::PH_LITERALS: begin
				cmd.has_lit = 1'b1;
				cmd.lit = in_byte;
				pc_v = (pc_v < DEPTH_V) ? pc_v + 1'b1 : pc_v;
				if (pl != '0) pl = pl - 9'd1;
				if (pl == '0) begin ph = lzvn_pkg::PH_OPCODE; run_m = 1'b1; end
			end
			default: dec = 1'b1;
		endcase

		if (dec) begin
			so = in_byte;
			ph = lzvn_pkg::PH_OPCODE;
			if (in_byte == lzvn_pkg::OP_LMATCH) ph = lzvn_pkg::PH_LMATCH_LEN;
			else if (in_byte == lzvn_pkg::OP_LLIT) ph = lzvn_pkg::PH_LLIT_LEN;
			else if (in_byte == lzvn_pkg::OP_NOP0 || in_byte == lzvn_pkg::OP_NOP1) ;
			else if (in_byte == lzvn_pkg::OP_EOS) begin
				ph = lzvn_pkg::PH_HALT;
				cmd.act = lzvn_pkg::ACT_STATUS; cmd.status = lzvn_pkg::ST_END;
			end else if (in_byte == lzvn_pkg::OP_UND0 || in_byte == lzvn_pkg::OP_UND1 ||
					in_byte == lzvn_pkg::OP_UND2 || in_byte == lzvn_pkg::OP_UND3 ||
					in_byte == lzvn_pkg::OP_UND4 || in_byte[7:4] == lzvn_pkg::HI_UND0 ||
					in_byte[7:4] == lzvn_pkg::HI_UND1) begin
				ph = lzvn_pkg::PH_HALT;
				cmd.act = lzvn_pkg::ACT_STATUS; cmd.status = lzvn_pkg::ST_BADOP;
			end else if (in_byte[7:4] == lzvn_pkg::HI_SMATCH) begin
				pm = 9'(in_byte[3:0]);
				run_m = 1'b1;
			end else if (in_byte[7:4] == lzvn_pkg::HI_SLIT) begin
				pl = 9'(in_byte[3:0]);
				pm = '0;
				if (pl != '0) ph = lzvn_pkg::PH_LITERALS;
				else run_m = 1'b1;
			end else if (in_byte[7:5] == lzvn_pkg::TOP_MED) begin
				pl = 9'(in_byte[4:3]);
				ph = lzvn_pkg::PH_MED_B1;
			end else begin
				pl = 9'(in_byte[7:6]);
				pm = 9'(in_byte[5:3]) + 9'd3;
				if (in_byte[2:0] == lzvn_pkg::LOW_LDIST) ph = lzvn_pkg::PH_LDIST_B1;
				else if (in_byte[2:0] == lzvn_pkg::LOW_PDIST) begin
					if (pl != '0) ph = lzvn_pkg::PH_LITERALS;
					else run_m = 1'b1;
				end else begin
					pd = 8'(in_byte[2:0]);
					ph = lzvn_pkg::PH_SDIST;
				end
			end
		end

		// Resolve the pending match: skip, reject or issue
		if (run_m) begin
			mlen = pm;
			pm = '0;
			if (mlen != '0 && prd != '0) begin
				if (lzvn_pkg::PC_W'(prd) > pc_v) begin
					ph = lzvn_pkg::PH_HALT;
					cmd.act = lzvn_pkg::ACT_STATUS; cmd.status = lzvn_pkg::ST_DIST;
				end else begin
					cmd.act = lzvn_pkg::ACT_MATCH;
					cmd.distance = prd;
					cmd.len = mlen;
					pc_sum = {1'b0, pc_v} + (lzvn_pkg::PC_W + 1)'(mlen);
					pc_v = (pc_sum >= {1'b0, DEPTH_V}) ? DEPTH_V : pc_sum[lzvn_pkg::PC_W-1:0];
				end
			end
		end
	end

	assign q_cmd  = cmd;
	assign q_push = in_valid && in_ready &&
		(cmd.restart || cmd.has_lit || cmd.act != lzvn_pkg::ACT_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= lzvn_pkg::PH_HEADER; hc_q <= '0; pl_q <= '0; pm_q <= '0;
			pd_q <= '0; so_q <= '0; prd_q <= '0; pc_q <= '0;
		end else if (in_valid && in_ready) begin
			ph_q <= ph; hc_q <= hc; pl_q <= pl; pm_q <= pm;
			pd_q <= pd; so_q <= so; prd_q <= prd; pc_q <= pc_v;
		end
	end

endmodule

>>> hw/rtl/lzvn_cmd_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lzvn_cmd_fifo
// Four-entry command queue between parser and executor.
// ---------------------------------------------------------------------------
module lzvn_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lzvn_pkg::cmd_t wdata,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output lzvn_pkg::cmd_t rdata
);

	lzvn_pkg::cmd_t ent_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;

	assign full  = (cnt_q == 3'd4);
	assign empty = (cnt_q == 3'd0);
	assign rdata = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 2'd1;
			if (pop) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + 3'(push) - 3'(pop);
		end
	end

endmodule

>>> hw/rtl/lzvn_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lzvn_back
// Executes commands: history ring writes, match copy and result packing.
// ---------------------------------------------------------------------------
module lzvn_back #(
	parameter int unsigned HISTORY_DEPTH    = 65536,
	parameter int unsigned LANES_PER_RESULT = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  lzvn_pkg::cmd_t q_head,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     out_bytes [lzvn_pkg::MAX_LANES],
	output logic [3:0]     out_count,
	output logic [1:0]     out_status,
	output logic           out_last
);

	localparam int unsigned AW = $clog2(HISTORY_DEPTH);
	localparam logic [3:0]  LANES_V = 4'(LANES_PER_RESULT);
	localparam logic [5:0]  MAXR_V  = 6'(lzvn_pkg::MAX_RESULTS);

	logic [7:0] mem [HISTORY_DEPTH];
	logic [7:0] rd_q;

	lzvn_pkg::bstate_t st_q, st_n;
	lzvn_pkg::cmd_t    cur_q;
	logic [AW-1:0] wp_q, src_q, wp_inc, src_inc, src_calc;
	logic [16:0]   wp_ext, d_ext, src_ext;
	logic [8:0]    len_q;
	logic [3:0]    lane_q;
	logic [5:0]    res_q;
	logic [7:0]    buf_q [lzvn_pkg::MAX_LANES];
	logic          ofree, ld_lit, ld_st, ld_m, emit_go, mem_we;
	logic [7:0]    mem_wd;
	logic [7:0]    ob_q [lzvn_pkg::MAX_LANES];
	logic [3:0]    oc_q;
	logic [1:0]    os_q;
	logic          ol_q, ov_q;

	assign ofree   = !ov_q || out_ready;
	assign wp_inc  = (wp_q == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + 1'b1;
	assign src_inc = (src_q == AW'(HISTORY_DEPTH - 1)) ? '0 : src_q + 1'b1;
	assign wp_ext  = 17'(wp_q);
	assign d_ext   = 17'(cur_q.distance);
	assign src_ext = (wp_ext >= d_ext) ? wp_ext - d_ext : wp_ext + 17'(HISTORY_DEPTH) - d_ext;
	assign src_calc = src_ext[AW-1:0];

	always_comb begin
		st_n = st_q; q_pop = 1'b0; ld_lit = 1'b0; ld_st = 1'b0; ld_m = 1'b0;
		emit_go = 1'b0;
		case (st_q)
			lzvn_pkg::B_IDLE: if (!q_empty) begin
				q_pop = 1'b1; st_n = lzvn_pkg::B_START;
			end
			lzvn_pkg::B_START: st_n = cur_q.has_lit ? lzvn_pkg::B_LIT : lzvn_pkg::B_ACT;
			lzvn_pkg::B_LIT: if (ofree) begin
				ld_lit = 1'b1; st_n = lzvn_pkg::B_ACT;
			end
			lzvn_pkg::B_ACT: begin
				case (cur_q.act)
					lzvn_pkg::ACT_MATCH: st_n = lzvn_pkg::B_RD;
					lzvn_pkg::ACT_STATUS: if (ofree) begin
						ld_st = 1'b1; st_n = lzvn_pkg::B_IDLE;
					end
					default: st_n = lzvn_pkg::B_IDLE;
				endcase
			end
			lzvn_pkg::B_RD: st_n = lzvn_pkg::B_WR;
			lzvn_pkg::B_WR:
				st_n = (lane_q + 4'd1 == LANES_V || len_q == 9'd1) ? lzvn_pkg::B_EMIT
					: lzvn_pkg::B_RD;
			lzvn_pkg::B_EMIT: begin
				// Results past the per-word limit are dropped, bytes still land in history
				emit_go = (res_q >= MAXR_V) || ofree;
				ld_m = ofree && (res_q < MAXR_V);
				if (emit_go) st_n = (len_q == '0) ? lzvn_pkg::B_IDLE : lzvn_pkg::B_RD;
			end
			default: st_n = lzvn_pkg::B_IDLE;
		endcase
	end

	assign mem_we = ld_lit || (st_q == lzvn_pkg::B_WR);
	assign mem_wd = ld_lit ? cur_q.lit : rd_q;

	always_ff @(posedge clk) begin
		if (mem_we) mem[wp_q] <= mem_wd;
		rd_q <= mem[src_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= lzvn_pkg::B_IDLE;
		else st_q <= st_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; res_q <= '0; lane_q <= '0;
			cur_q <= '0; src_q <= '0; len_q <= '0;
			for (int i = 0; i < lzvn_pkg::MAX_LANES; i++) buf_q[i] <= '0;
		end else begin
			if (q_pop) cur_q <= q_head;
			if (st_q == lzvn_pkg::B_START) begin
				res_q <= '0;
				if (cur_q.restart) wp_q <= '0;
			end
			if (ld_lit) begin
				wp_q <= wp_inc;
				res_q <= 6'd1;
			end
			if (st_q == lzvn_pkg::B_ACT) begin
				src_q <= src_calc;
				len_q <= cur_q.len;
				lane_q <= '0;
			end
			if (st_q == lzvn_pkg::B_WR) begin
				buf_q[lane_q[2:0]] <= rd_q;
				wp_q <= wp_inc;
				src_q <= src_inc;
				len_q <= len_q - 9'd1;
				lane_q <= lane_q + 4'd1;
			end
			if (emit_go) begin
				lane_q <= '0;
				for (int i = 0; i < lzvn_pkg::MAX_LANES; i++) buf_q[i] <= '0;
				if (res_q < MAXR_V) res_q <= res_q + 6'd1;
			end
		end
	end

	// Output register: holds a finished result while the sink stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (ld_lit || ld_st || ld_m) ov_q <= 1'b1;
		else if (out_ready) ov_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ld_lit) begin
			ob_q[0] <= cur_q.lit;
			for (int i = 1; i < lzvn_pkg::MAX_LANES; i++) ob_q[i] <= '0;
			oc_q <= 4'd1; os_q <= lzvn_pkg::ST_OK;
			ol_q <= (cur_q.act == lzvn_pkg::ACT_NONE);
		end else if (ld_st) begin
			for (int i = 0; i < lzvn_pkg::MAX_LANES; i++) ob_q[i] <= '0;
			oc_q <= '0; os_q <= cur_q.status; ol_q <= 1'b1;
		end else if (ld_m) begin
			for (int i = 0; i < lzvn_pkg::MAX_LANES; i++) ob_q[i] <= buf_q[i];
			oc_q <= lane_q; os_q <= lzvn_pkg::ST_OK;
			ol_q <= (len_q == '0) || (res_q == MAXR_V - 6'd1);
		end
	end

	assign out_valid  = ov_q;
	assign out_bytes  = ob_q;
	assign out_count  = oc_q;
	assign out_status = os_q;
	assign out_last   = ol_q;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LZVN stream decoder.
// Drives compressed words with random bursts and gaps, and stalls the result
// side on changing patterns. A scoreboard holds its own copy of the decoder
// state, predicts every result word and checks each one field by field. Most
// of the stimulus is well-formed streams with random content. Headers of
// several lengths, restarts, ignored bytes after a halt and random noise are
// mixed in.
// ---------------------------------------------------------------------------
module tb_top;

	localparam int unsigned HIST_DEPTH  = 65536;
	localparam int unsigned LANES       = 8;
	localparam int unsigned ITEM_TARGET = 410;
	localparam int unsigned CYCLE_LIMIT = 2000000;
	localparam int unsigned SETTLE      = 200;

	// One decoded result word, as seen on m_axis
	typedef struct packed {
		logic [63:0] bytes;
		logic [3:0]  count;
		logic [1:0]  status;
		logic        last;
	} result_t;

	// Decoder state copy; predicts result words and checks them in order
	class lzvn_scoreboard;
		bit [7:0]          hist [HIST_DEPTH];
		bit [15:0]         wr_ptr;
		int unsigned       produced;
		bit [15:0]         prev_dist;
		lzvn_pkg::phase_t  phase;
		int unsigned       hdr_count;
		int unsigned       lits_left;
		int unsigned       match_len;
		bit [7:0]          part_dist;
		bit [7:0]          last_op;
		bit                halted;
		bit [3:0]          hdr_len;
		int unsigned       lane;
		result_t           step_out[$];
		result_t           awaited[$];
		int unsigned       errors;

		function new();
			restart();
			halted  = 0;
			hdr_len = 4'd12;
			errors  = 0;
		endfunction

		function void restart();
			wr_ptr    = '0;
			produced  = 0;
			prev_dist = '0;
			phase     = lzvn_pkg::PH_HEADER;
			hdr_count = 0;
			lits_left = 0;
			match_len = 0;
			part_dist = '0;
			last_op   = '0;
			halted    = 0;
		endfunction

		function void emit(bit [7:0] b);
			result_t r;
			if (lane == 0) begin
				if (step_out.size() >= lzvn_pkg::MAX_RESULTS)
					return;
				r = '0;
				step_out = {step_out, r};
			end
			r = step_out[$];
			r.bytes[lane*8 +: 8] = b;
			lane++;
			r.count = 4'(lane);
			step_out[$] = r;
			if (lane >= LANES)
				lane = 0;
		endfunction

		function void stop_with(logic [1:0] st);
			result_t r;
			lane = 0;
			if (step_out.size() < lzvn_pkg::MAX_RESULTS) begin
				r = '0;
				r.status = st;
				step_out = {step_out, r};
			end
			halted = 1;
			phase  = lzvn_pkg::PH_HALT;
		endfunction

		function void store(bit [7:0] b);
			hist[wr_ptr] = b;
			wr_ptr++;
			if (produced < HIST_DEPTH)
				produced++;
		endfunction

		function void copy_match();
			int unsigned len;
			bit [15:0]   src;
			bit [7:0]    b;
			len = match_len;
			match_len = 0;
			if (len == 0 || prev_dist == 0)
				return;
			if (prev_dist > produced) begin
				stop_with(lzvn_pkg::ST_DIST);
				return;
			end
			src = wr_ptr - prev_dist;
			for (int i = 0; i < len; i++) begin
				b = hist[src];
				src++;
				store(b);
				emit(b);
			end
			lane = 0;
		endfunction

		function void begin_run();
			if (lits_left > 0) begin
				phase = lzvn_pkg::PH_LITERALS;
			end else begin
				phase = lzvn_pkg::PH_OPCODE;
				copy_match();
			end
		endfunction

		function void decode_op(bit [7:0] op);
			last_op = op;
			phase = lzvn_pkg::PH_OPCODE;
			if (op == lzvn_pkg::OP_LMATCH) begin
				phase = lzvn_pkg::PH_LMATCH_LEN;
			end else if (op == lzvn_pkg::OP_LLIT) begin
				phase = lzvn_pkg::PH_LLIT_LEN;
			end else if (op == lzvn_pkg::OP_NOP0 || op == lzvn_pkg::OP_NOP1) begin
			end else if (op == lzvn_pkg::OP_EOS) begin
				stop_with(lzvn_pkg::ST_END);
			end else if (op == lzvn_pkg::OP_UND0 || op == lzvn_pkg::OP_UND1 ||
					op == lzvn_pkg::OP_UND2 || op == lzvn_pkg::OP_UND3 ||
					op == lzvn_pkg::OP_UND4) begin
				stop_with(lzvn_pkg::ST_BADOP);
			end else if (op[7:4] == lzvn_pkg::HI_SMATCH) begin
				match_len = op[3:0];
				copy_match();
			end else if (op[7:4] == lzvn_pkg::HI_SLIT) begin
				lits_left = op[3:0];
				match_len = 0;
				begin_run();
			end else if (op[7:4] == lzvn_pkg::HI_UND0 || op[7:4] == lzvn_pkg::HI_UND1) begin
				stop_with(lzvn_pkg::ST_BADOP);
			end else if (op[7:5] == lzvn_pkg::TOP_MED) begin
				lits_left = op[4:3];
				phase = lzvn_pkg::PH_MED_B1;
			end else begin
				lits_left = op[7:6];
				match_len = op[5:3] + 3;
				if (op[2:0] == lzvn_pkg::LOW_LDIST) begin
					phase = lzvn_pkg::PH_LDIST_B1;
				end else if (op[2:0] == lzvn_pkg::LOW_PDIST) begin
					begin_run();
				end else begin
					part_dist = op[2:0];
					phase = lzvn_pkg::PH_SDIST;
				end
			end
		endfunction

		// Advance the state by one accepted word and queue what it yields
		function void note_input(bit [7:0] b, bit start);
			step_out.delete();
			lane = 0;
			if (start)
				restart();
			if (halted) begin
				phase = lzvn_pkg::PH_HALT;
				return;
			end
			case (phase)
			lzvn_pkg::PH_HEADER: begin
				if (hdr_count >= hdr_len)
					decode_op(b);
				else
					hdr_count = (hdr_count + 1) & 15;
			end
			lzvn_pkg::PH_LMATCH_LEN: begin
				match_len = b + 16;
				phase = lzvn_pkg::PH_OPCODE;
				copy_match();
			end
			lzvn_pkg::PH_LLIT_LEN: begin
				lits_left = b + 16;
				match_len = 0;
				phase = lzvn_pkg::PH_LITERALS;
			end
			lzvn_pkg::PH_MED_B1: begin
				match_len = (last_op[2:0] << 2) + b[1:0] + 3;
				part_dist = b >> 2;
				phase = lzvn_pkg::PH_MED_B2;
			end
			lzvn_pkg::PH_MED_B2: begin
				prev_dist = {b, 6'b0} | part_dist;
				begin_run();
			end
			lzvn_pkg::PH_LDIST_B1: begin
				part_dist = b;
				phase = lzvn_pkg::PH_LDIST_B2;
			end
			lzvn_pkg::PH_LDIST_B2: begin
				prev_dist = {b, part_dist};
				begin_run();
			end
			lzvn_pkg::PH_SDIST: begin
				prev_dist = {part_dist, b};
				begin_run();
			end
			lzvn_pkg::PH_LITERALS: begin
				store(b);
				emit(b);
				lane = 0;
				if (lits_left > 0)
					lits_left--;
				if (lits_left == 0) begin
					phase = lzvn_pkg::PH_OPCODE;
					copy_match();
				end
			end
			default: decode_op(b);
			endcase
			if (step_out.size() > 0)
				step_out[$].last = 1'b1;
			awaited = {awaited, step_out};
		endfunction

		function void report(string what, logic [71:0] got, logic [71:0] want);
			errors++;
			if (errors <= 30)
				$display("mismatch %0s: got %0h want %0h", what, got, want);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (awaited.size() == 0) begin
				report("unexpected word", got, '0);
				return;
			end
			want = awaited.pop_front();
			for (int i = 0; i < LANES; i++)
				if (got.bytes[i*8 +: 8] !== want.bytes[i*8 +: 8])
					report($sformatf("out_byte%0d", i), got.bytes[i*8 +: 8],
						want.bytes[i*8 +: 8]);
			if (got.count !== want.count)
				report("byte_count", got.count, want.count);
			if (got.status !== want.status)
				report("status", got.status, want.status);
			if (got.last !== want.last)
				report("last_of_run", got.last, want.last);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [3:0]  cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;  // out_byte0..out_byte7, byte_count, 4 zero bits
	logic [1:0]  m_axis_tuser;  // status
	logic        m_axis_tlast;  // last_of_run

	lzvn_scoreboard sb = new();

	int unsigned cycles = 0;
	int unsigned words_sent = 0;
	int unsigned burst_left = 0;
	int unsigned hold_off = 0;
	bit          start_next = 0;

	lzvn_stream_decoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #10 clk = ~clk;

	// Stop a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL lzvn_stream_decoder");
			$finish;
		end
	end

	// Check every accepted result word
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result({m_axis_tdata[63:0], m_axis_tdata[67:64], m_axis_tuser,
				m_axis_tlast});
	end

	// Receiver: long hold-off when asked, otherwise a stall pattern that is redrawn
	// at random whenever a tick counter wraps (free running, coin toss, or one stall in four)
	always @(negedge clk) begin : rx_pattern
		static int unsigned mode = 0;
		static int unsigned tick = 0;
		tick++;
		if (tick % 64 == 0)
			mode = $urandom_range(0, 2);
		if (hold_off > 0) begin
			hold_off--;
			m_axis_tready <= 1'b0;
		end else begin
			case (mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= 1'($urandom_range(0, 1));
			default: m_axis_tready <= (tick % 4 != 0);
			endcase
		end
	end

	// Offer one word; hold it until accepted, then update the prediction.
	// Entered and left at a falling edge.
	task automatic send_word(bit [7:0] b);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= start_next;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_input(b, start_next);
		start_next = 0;
		words_sent++;
		@(negedge clk);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 5)) @(negedge clk);
			end
		end
	endtask

	// Pause the sender until every predicted word has come, then let the
	// executor settle. Leaves valid low.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.awaited.size() != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_header_length(bit [3:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.hdr_len = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic bit plain_op(bit [7:0] op);
		if (op[7:4] == lzvn_pkg::HI_SMATCH || op[7:4] == lzvn_pkg::HI_SLIT ||
				op[7:4] == lzvn_pkg::HI_UND0 || op[7:4] == lzvn_pkg::HI_UND1 ||
				op[7:5] == lzvn_pkg::TOP_MED)
			return 0;
		return !(op == lzvn_pkg::OP_EOS || op == lzvn_pkg::OP_NOP0 ||
			op == lzvn_pkg::OP_NOP1 || op == lzvn_pkg::OP_UND0 ||
			op == lzvn_pkg::OP_UND1 || op == lzvn_pkg::OP_UND2 ||
			op == lzvn_pkg::OP_UND3 || op == lzvn_pkg::OP_UND4);
	endfunction

	function automatic int unsigned pick_dist(int unsigned cap);
		int unsigned hi;
		hi = (sb.produced < cap) ? sb.produced : cap;
		return $urandom_range(1, hi);
	endfunction

	task automatic send_literals(int unsigned n);
		repeat (n) send_word(8'($urandom_range(0, 255)));
	endtask

	// One random opcode with its operands and literals
	task automatic send_random_op();
		int unsigned sel;
		int unsigned d;
		int unsigned n;
		bit [7:0]    op;
		sel = $urandom_range(0, 99);
		if (sb.produced == 0 && sel >= 22 && sel < 78)
			sel = 0;
		if (sel < 18) begin
			n = $urandom_range(1, 15);
			send_word({lzvn_pkg::HI_SLIT, 4'(n)});
			send_literals(n);
		end else if (sel < 22) begin
			n = $urandom_range(0, 5);
			send_word(lzvn_pkg::OP_LLIT);
			send_word(8'(n));
			send_literals(n + 16);
		end else if (sel < 36) begin
			do op = 8'($urandom_range(0, 255)); while (op[2:0] > 3'd5 || !plain_op(op));
			d = pick_dist(1535);
			send_word({op[7:3], 3'(d >> 8)});
			send_word(d[7:0]);
			send_literals(op[7:6]);
		end else if (sel < 48) begin
			op = {lzvn_pkg::TOP_MED, 5'($urandom_range(0, 31))};
			d = pick_dist(16383);
			n = $urandom_range(0, 3);
			send_word(op);
			send_word({d[5:0], n[1:0]});
			send_word(d[13:6]);
			send_literals(op[4:3]);
		end else if (sel < 58) begin
			do op = {5'($urandom_range(0, 31)), lzvn_pkg::LOW_LDIST}; while (!plain_op(op));
			d = pick_dist(65535);
			send_word(op);
			send_word(d[7:0]);
			send_word(d[15:8]);
			send_literals(op[7:6]);
		end else if (sel < 68) begin
			do op = {5'($urandom_range(0, 31)), lzvn_pkg::LOW_PDIST}; while (!plain_op(op));
			send_word(op);
			send_literals(op[7:6]);
		end else if (sel < 75) begin
			send_word({lzvn_pkg::HI_SMATCH, 4'($urandom_range(1, 15))});
		end else if (sel < 78) begin
			send_word(lzvn_pkg::OP_LMATCH);
			send_word(($urandom_range(0, 15) == 0) ? 8'hFF : 8'($urandom_range(0, 24)));
		end else if (sel < 85) begin
			send_word($urandom_range(0, 1) ? lzvn_pkg::OP_NOP0 : lzvn_pkg::OP_NOP1);
		end else begin
			// noise: any byte at all
			send_word(8'($urandom_range(0, 255)));
		end
	endtask

	// A whole stream: restart, header, opcodes, then for most streams a way of ending
	task automatic send_stream(int unsigned n_ops);
		int unsigned how;
		start_next = 1;
		repeat (sb.hdr_len) send_word(8'($urandom_range(0, 255)));
		repeat (n_ops) send_random_op();
		how = $urandom_range(0, 9);
		case (how)
		0, 1, 2, 3: send_word(lzvn_pkg::OP_EOS);
		4: send_word($urandom_range(0, 1) ? {lzvn_pkg::HI_UND1, 4'($urandom_range(0, 15))}
			: lzvn_pkg::OP_UND2);
		5: begin
			send_word({5'd0, lzvn_pkg::LOW_LDIST});
			send_word(8'hFF);
			send_word(8'hFF);
		end
		default: ;
		endcase
		// words after a halt are dropped
		if (how < 6)
			send_literals($urandom_range(0, 2));
	endtask

	initial begin
		bit [3:0] hdr_plan [6] = '{4'd15, 4'd0, 4'd5, 4'd1, 4'd12, 4'd0};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// Directed: no header, literal extremes, previous distance still zero,
		// overlapped short match, longest match, medium and large distance forms
		write_header_length(4'd0);
		start_next = 1;
		send_word({lzvn_pkg::HI_SLIT, 4'd3});
		send_word(8'h00);
		send_word(8'hFF);
		send_word(8'hA5);
		send_word(8'h46);            // one literal, then a match at distance zero
		send_word(8'h5A);
		send_word(8'h08);            // small distance 1, length 4
		send_word(8'h01);
		send_word(lzvn_pkg::OP_LMATCH); // longest match
		send_word(8'hFF);
		send_word({lzvn_pkg::HI_SMATCH, 4'd15});
		send_word({lzvn_pkg::TOP_MED, 5'b00111});
		send_word({6'd2, 2'd3});
		send_word(8'h00);
		send_word({5'b00111, lzvn_pkg::LOW_LDIST});
		send_word(8'h05);
		send_word(8'h00);
		send_word(lzvn_pkg::OP_NOP0);
		send_word(lzvn_pkg::OP_NOP1);
		send_word(lzvn_pkg::OP_EOS);
		send_word(8'h77);            // dropped, halted
		start_next = 1;
		send_word(lzvn_pkg::OP_UND0);
		start_next = 1;
		send_word({5'd0, lzvn_pkg::LOW_LDIST}); // distance beyond an empty history
		send_word(8'h01);
		send_word(8'h00);
		drain();

		// Header length lowered while the header is being skipped
		write_header_length(4'd15);
		start_next = 1;
		send_literals(5);
		drain();
		write_header_length(4'd3);
		send_word({lzvn_pkg::HI_SLIT, 4'd1});
		send_word(8'h3C);
		drain();

		// Random phases, one header length each
		for (int p = 0; words_sent < ITEM_TARGET; p++) begin
			write_header_length((p < 6) ? hdr_plan[p] : 4'($urandom_range(0, 15)));
			for (int s = 0; s < 3 && words_sent < ITEM_TARGET; s++) begin
				if (p == 2 && s == 1)
					hold_off = 400;   // receiver backs up, input stalls
				send_stream($urandom_range(2, 10));
			end
			drain();
		end

		repeat (SETTLE) @(negedge clk);
		if (sb.errors == 0 && sb.awaited.size() == 0)
			$display("PASS lzvn_stream_decoder");
		else
			$display("FAIL lzvn_stream_decoder");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/lzvn_pkg.sv
hw/rtl/lzvn_front.sv
hw/rtl/lzvn_cmd_fifo.sv
hw/rtl/lzvn_back.sv
hw/rtl/lzvn_stream_decoder.sv
tb/tb_top.sv
